### hdl/drts_pkg.sv
// Shared types and constants for the dual rumble tone synthesizer.
// Used by the controller, the datapath, the tone lanes, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drts_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_INDEX_BITS_DEF = 10;
  localparam int unsigned LEVEL_BITS_DEF      = 16;

  // Fixed widths of the stream fields and the period register.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned ITEM_W   = 2 * SAMPLE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd89478;

  // Tone frequencies in Hz and the level ramp rate in 1/s.
  localparam logic [7:0] LOW_HZ    = 8'd60;
  localparam logic [7:0] HIGH_HZ   = 8'd180;
  localparam logic [7:0] RAMP_RATE = 8'd250;

  // Smoothing coefficient is Q0.32 with 1.0 included, so 33 bits.
  localparam int unsigned COEF_W = 33;

  // Quarter-wave polynomial values are unsigned Q1.30 and fit in 31 bits.
  localparam int unsigned POLY_W = 31;
  localparam logic [POLY_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [POLY_W-1:0] SC1 = 31'd1686629713;
  localparam logic [POLY_W-1:0] SC3 = 31'd693598668;
  localparam logic [POLY_W-1:0] SC5 = 31'd85569306;
  localparam logic [POLY_W-1:0] SC7 = 31'd5026995;
  localparam logic [POLY_W-1:0] SC9 = 31'd172273;

  // Largest output magnitude.
  localparam logic [16:0] MAG_MAX = 17'd32767;

  // One datapath step per code.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LEVEL,
    OP_SQUARE,
    OP_P9,
    OP_P7,
    OP_P5,
    OP_P3,
    OP_P1,
    OP_SCALE,
    OP_FINISH
  } drts_op_e;

  typedef struct packed {
    logic     take_item;
    drts_op_e op;
  } drts_cmd_t;

endpackage

`default_nettype wire

### hdl/drts_lane.sv
// One tone lane: level smoothing, phase accumulator and polynomial sine
// around a single shared multiplier. Stepped by commands from the controller.
// Depends on drts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drts_lane #(
  parameter int unsigned PHASE_BITS      = drts_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_INDEX_BITS = drts_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned LEVEL_BITS      = drts_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire drts_pkg::drts_cmd_t                cmd_i,
  input  wire logic [drts_pkg::SAMPLE_W-1:0]      target_i,
  input  wire logic [drts_pkg::COEF_W-1:0]        coef_i,
  input  wire logic [PHASE_BITS-1:0]              inc_i,
  output logic      [drts_pkg::SAMPLE_W-1:0]      sample_o
);
  import drts_pkg::*;

  localparam int unsigned MB  = (LEVEL_BITS > POLY_W) ? LEVEL_BITS : POLY_W;
  localparam int unsigned PW  = COEF_W + MB;
  localparam int unsigned SH  = LEVEL_BITS + 15;
  localparam int unsigned TGT_SHIFT = 40 - LEVEL_BITS;
  localparam int unsigned FRAC_ZEROS = 32 - SINE_INDEX_BITS;
  localparam logic [PW:0] ROUND_LVL = (PW+1)'(1) << 31;
  localparam logic [PW:0] ROUND_OUT = (PW+1)'(1) << (SH - 1);

  logic [LEVEL_BITS-1:0]      target_q;
  logic [LEVEL_BITS-1:0]      level_q;
  logic [PHASE_BITS-1:0]      phase_q;
  logic [POLY_W-1:0]          x_q;
  logic [POLY_W-1:0]          x2_q;
  logic [1:0]                 quad_q;
  logic [PW-1:0]              prod_q;

  logic [39:0]                tgt_wide;
  logic [LEVEL_BITS-1:0]      tgt_scaled;
  logic                       dir_down;
  logic [LEVEL_BITS-1:0]      diff;
  logic [PW:0]                lvl_sum;
  logic [LEVEL_BITS-1:0]      lvl_step;
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [29:0]                x_raw;
  logic [POLY_W-1:0]          x_fold;
  logic [POLY_W-1:0]          ptop;
  logic [POLY_W-1:0]          s_cap;
  logic [COEF_W-1:0]          mul_a;
  logic [MB-1:0]              mul_b;
  logic [PW-1:0]              prod_d;
  logic [PW:0]                out_sum;
  logic [16:0]                mag_wide;
  logic [16:0]                mag;

  // Target rescaled from 16 bits to the level width.
  assign tgt_wide   = {target_i, 24'b0} >> TGT_SHIFT;
  assign tgt_scaled = tgt_wide[LEVEL_BITS-1:0];

  assign dir_down = (target_q < level_q);
  assign diff     = dir_down ? (level_q - target_q) : (target_q - level_q);
  assign lvl_sum  = {1'b0, prod_q} + ROUND_LVL;
  assign lvl_step = lvl_sum[32 +: LEVEL_BITS];

  // Fold the table angle onto a quarter wave.
  assign idx    = phase_q[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign x_raw  = {idx[SINE_INDEX_BITS-3:0], {FRAC_ZEROS{1'b0}}};
  assign x_fold = idx[SINE_INDEX_BITS-2] ? (ONE_Q30 - {1'b0, x_raw}) : {1'b0, x_raw};

  assign ptop  = prod_q[30 +: POLY_W];
  assign s_cap = (ptop > ONE_Q30) ? ONE_Q30 : ptop;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_LEVEL: begin
        mul_a = coef_i;
        mul_b = MB'(diff);
      end
      OP_SQUARE: begin
        mul_a = COEF_W'(x_q);
        mul_b = MB'(x_q);
      end
      OP_P9: begin
        mul_a = COEF_W'(ptop);
        mul_b = MB'(SC9);
      end
      OP_P7: begin
        mul_a = COEF_W'(x2_q);
        mul_b = MB'(SC7 - ptop);
      end
      OP_P5: begin
        mul_a = COEF_W'(x2_q);
        mul_b = MB'(SC5 - ptop);
      end
      OP_P3: begin
        mul_a = COEF_W'(x2_q);
        mul_b = MB'(SC3 - ptop);
      end
      OP_P1: begin
        mul_a = COEF_W'(x_q);
        mul_b = MB'(SC1 - ptop);
      end
      OP_SCALE: begin
        mul_a = COEF_W'(s_cap);
        mul_b = MB'(level_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // Rounded, saturated and signed output from the final product.
  assign out_sum  = {1'b0, prod_q} + ROUND_OUT;
  assign mag_wide = out_sum[SH +: 17];
  assign mag      = (mag_wide > MAG_MAX) ? MAG_MAX : mag_wide;
  assign sample_o = quad_q[1] ? (SAMPLE_W'(0) - mag[SAMPLE_W-1:0]) : mag[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      phase_q <= '0;
    end else begin
      if (cmd_i.op == OP_SQUARE) begin
        level_q <= dir_down ? (level_q - lvl_step) : (level_q + lvl_step);
      end
      if (cmd_i.op == OP_FINISH) begin
        phase_q <= phase_q + inc_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      target_q <= tgt_scaled;
    end
    case (cmd_i.op)
      OP_LEVEL: begin
        prod_q <= prod_d;
        x_q    <= x_fold;
        quad_q <= idx[SINE_INDEX_BITS-1 -: 2];
      end
      OP_P9: begin
        prod_q <= prod_d;
        x2_q   <= ptop;
      end
      OP_SQUARE, OP_P7, OP_P5, OP_P3, OP_P1, OP_SCALE: begin
        prod_q <= prod_d;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/drts_datapath.sv
// Datapath: sample period register, derived coefficient and phase steps,
// the two tone lanes and the output data register.
// Depends on drts_pkg and drts_lane.
`timescale 1ns / 1ps
`default_nettype none

module drts_datapath #(
  parameter int unsigned PHASE_BITS      = drts_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_INDEX_BITS = drts_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned LEVEL_BITS      = drts_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [drts_pkg::PERIOD_W-1:0] cfg_data_i,
  input  wire drts_pkg::drts_cmd_t           cmd_i,
  input  wire logic [drts_pkg::ITEM_W-1:0]   s_data_i,
  output logic      [drts_pkg::ITEM_W-1:0]   m_data_o
);
  import drts_pkg::*;

  localparam int unsigned INC_SHIFT = 80 - PHASE_BITS;
  localparam logic [39:0] COEF_ONE  = 40'h1_0000_0000;

  logic [PERIOD_W-1:0]   period_q;
  logic [ITEM_W-1:0]     out_q;
  logic [39:0]           coef_full;
  logic [COEF_W-1:0]     coef;
  logic [37:0]           inc_low_full;
  logic [37:0]           inc_high_full;
  logic [85:0]           inc_low_wide;
  logic [85:0]           inc_high_wide;
  logic [SAMPLE_W-1:0]   left_sample;
  logic [SAMPLE_W-1:0]   right_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  // The smoothing coefficient saturates at 1.0.
  assign coef_full = 40'(period_q) * 40'(RAMP_RATE);
  assign coef      = (coef_full > COEF_ONE) ? COEF_ONE[COEF_W-1:0] : coef_full[COEF_W-1:0];

  // Phase steps in Q0.32, rescaled to the accumulator width.
  assign inc_low_full  = 38'(period_q) * 38'(LOW_HZ);
  assign inc_high_full = 38'(period_q) * 38'(HIGH_HZ);
  assign inc_low_wide  = {inc_low_full, 48'b0} >> INC_SHIFT;
  assign inc_high_wide = {inc_high_full, 48'b0} >> INC_SHIFT;

  drts_lane #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .LEVEL_BITS      (LEVEL_BITS)
  ) u_lane_low (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .target_i (s_data_i[SAMPLE_W-1:0]),
    .coef_i   (coef),
    .inc_i    (inc_low_wide[PHASE_BITS-1:0]),
    .sample_o (left_sample)
  );

  drts_lane #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .LEVEL_BITS      (LEVEL_BITS)
  ) u_lane_high (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .target_i (s_data_i[ITEM_W-1:SAMPLE_W]),
    .coef_i   (coef),
    .inc_i    (inc_high_wide[PHASE_BITS-1:0]),
    .sample_o (right_sample)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      out_q <= {right_sample, left_sample};
    end
  end

  assign m_data_o = out_q;

endmodule

`default_nettype wire

### hdl/drts_ctrl.sv
// Controller: sequences the multiply steps of one item and owns the
// stream handshakes and the output valid flag.
// Depends on drts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drts_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output drts_pkg::drts_cmd_t      cmd_o
);
  import drts_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LEVEL  = 10'b00_0000_0010,
    ST_SQUARE = 10'b00_0000_0100,
    ST_P9     = 10'b00_0000_1000,
    ST_P7     = 10'b00_0001_0000,
    ST_P5     = 10'b00_0010_0000,
    ST_P3     = 10'b00_0100_0000,
    ST_P1     = 10'b00_1000_0000,
    ST_SCALE  = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } drts_state_e;

  drts_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        take;

  assign out_free  = !out_valid_q || m_ready_i;
  // A new item may enter while the finished one moves to the output register.
  assign s_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && out_free);
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o.take_item = take;
    cmd_o.op        = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        cmd_o.op = OP_LEVEL;
        state_d  = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.op = OP_SQUARE;
        state_d  = ST_P9;
      end
      ST_P9: begin
        cmd_o.op = OP_P9;
        state_d  = ST_P7;
      end
      ST_P7: begin
        cmd_o.op = OP_P7;
        state_d  = ST_P5;
      end
      ST_P5: begin
        cmd_o.op = OP_P5;
        state_d  = ST_P3;
      end
      ST_P3: begin
        cmd_o.op = OP_P3;
        state_d  = ST_P1;
      end
      ST_P1: begin
        cmd_o.op = OP_P1;
        state_d  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = take ? ST_LEVEL : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.op == OP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hdl/dual_rumble_tone_synth.sv
// Dual rumble tone synthesizer, top level.
// Joins the controller and the datapath. Depends on drts_pkg, drts_ctrl, drts_datapath.
//
// Usage:
//   Each input item is one sample tick carrying the low and high motor target
//   levels. Each produces exactly one output item: left = low tone (60 Hz),
//   right = high tone (180 Hz), Q1.15 signed, scaled by the smoothed levels.
//   The config channel writes the sample period (Q0.32 seconds); write it only
//   while no item is in flight. It is always ready.
// Sequence:
//   An accepted item steps through the states LEVEL, SQUARE, P9, P7, P5, P3,
//   P1, SCALE and FINISH, and its result enters the output register from
//   FINISH; the next item can be accepted in FINISH once the output register
//   is free, so a new item enters as the last one leaves. The sequence is
//   set by eight dependent multiply steps (level update, square, five Horner
//   terms, scaling) sharing one multiplier per tone, and a last step that rounds the result into the output register.
// Reset:
//   Levels and phases clear to zero, the period returns to 1/48000 s and no
//   output is valid.
// Backpressure:
//   A result waits in the output register while m_axis_tready is low; the
//   next item is still worked on and stalls only in its final step.
`timescale 1ns / 1ps
`default_nettype none

module dual_rumble_tone_synth #(
  parameter int unsigned PHASE_BITS      = drts_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_INDEX_BITS = drts_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned LEVEL_BITS      = drts_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input items: [15:0] target_low_level, [31:16] target_high_level.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [drts_pkg::ITEM_W-1:0]   s_axis_tdata,
  // Output items: [15:0] left_sample, [31:16] right_sample.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [drts_pkg::ITEM_W-1:0]   m_axis_tdata,
  // Sample period register write.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [drts_pkg::PERIOD_W-1:0] cfg_data_i
);
  import drts_pkg::*;

  drts_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  drts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  drts_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .LEVEL_BITS      (LEVEL_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .s_data_i   (s_axis_tdata),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

### hdl/drts_checker.sv
// Port-level checks for the dual rumble tone synthesizer, bound to the top.
// Depends on drts_pkg and dual_rumble_tone_synth.
`timescale 1ns / 1ps
`default_nettype none

module drts_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [drts_pkg::ITEM_W-1:0]   m_axis_tdata
);

  logic in_take;

  assign in_take = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output item changed while stalled");

  // The block is busy right after it takes an item.
  a_busy_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !s_axis_tready)
    else $error("item accepted while the previous one was still in work");

  // Still busy in the last multiply step.
  a_busy_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> ##8 !s_axis_tready)
    else $error("item accepted before the sine sequence finished");

  // A result into an empty output register traces back to an item accepted ahead of its multiply sequence.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_take, 10))
    else $error("output item without a matching input item");

endmodule

bind dual_rumble_tone_synth drts_checker u_drts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
